### hdl/pdsd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the duty-to-speed mapping of the pwm speed detector
package pdsd_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int TIME_IN_W      = 32;
	localparam int SPEED_W        = 4;
	localparam int RATIO_W        = 7;
	localparam int S_TDATA_W      = 40;
	localparam int M_TDATA_W      = 8;
	localparam int SPEED_LEVELS   = 13;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 4'd12;
	localparam logic [SPEED_W-1:0] SPEED_OFF = 4'd0;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_WINDOW = 1'b1;

	localparam logic [RATIO_W-1:0] DUTY_TABLE [SPEED_LEVELS] = '{
		7'd5, 7'd20, 7'd28, 7'd35, 7'd42, 7'd49, 7'd56,
		7'd63, 7'd70, 7'd78, 7'd87, 7'd95, 7'd100
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		DIV_IDLE,
		DIV_MUL1,
		DIV_MUL2,
		DIV_RUN,
		DIV_FIN
	} div_state_t;

	typedef struct packed {
		logic start;
		logic clr;
		logic rise;
		logic acc;
		logic rec;
	} edge_op_t;

	// first table entry not below the ratio, saturating at full speed
	function automatic logic [SPEED_W-1:0] speed_of_ratio(input logic [RATIO_W-1:0] ratio,
		input logic over);
		logic [SPEED_W-1:0] s;
		logic               hit;
		s   = SPEED_MAX;
		hit = 1'b0;
		for (int i = 0; i < SPEED_LEVELS - 1; i++) begin
			if (!hit && ratio <= DUTY_TABLE[i]) begin
				s   = SPEED_W'(i);
				hit = 1'b1;
			end
		end
		if (over) begin
			s = SPEED_MAX;
		end
		return s;
	endfunction

endpackage

### hdl/pdsd_edge_acc.sv
`timescale 1ns / 1ps
// bit-serial edge unit: pulse start, high time and the two running sums
module pdsd_edge_acc #(
	parameter int TIME_WIDTH = pdsd_pkg::TIME_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pdsd_pkg::edge_op_t        op,
	input  logic [TIME_WIDTH-1:0]     now,
	output logic [TIME_WIDTH-1:0]     high_sum,
	output logic [TIME_WIDTH-1:0]     period_sum,
	output logic                      done
);
	import pdsd_pkg::*;

	localparam int CNT_W = $clog2(TIME_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_WIDTH - 1);

	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] start_q;
	logic [TIME_WIDTH-1:0] hlen_q;
	logic [TIME_WIDTH-1:0] psum_q;
	logic [TIME_WIDTH-1:0] hsum_q;
	edge_op_t              op_q;
	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  brw_q;
	logic                  cp_q;
	logic                  ch_q;

	logic n_b, p_b, hl_b, ps_b, hs_b;
	logic diff_b, brw_d;
	logic sp_b, cp_d;
	logic sh_b, ch_d;
	logic p_new, hl_new, ps_new, hs_new;

	always_comb begin
		n_b  = now_q[0];
		p_b  = start_q[0] & ~op_q.clr;
		hl_b = hlen_q[0] & ~op_q.clr;
		ps_b = psum_q[0] & ~op_q.clr;
		hs_b = hsum_q[0] & ~op_q.clr;

		diff_b = n_b ^ p_b ^ brw_q;
		brw_d  = (~n_b & p_b) | (~(n_b ^ p_b) & brw_q);

		sp_b = ps_b ^ diff_b ^ cp_q;
		cp_d = (ps_b & diff_b) | (ps_b & cp_q) | (diff_b & cp_q);

		sh_b = hs_b ^ hl_b ^ ch_q;
		ch_d = (hs_b & hl_b) | (hs_b & ch_q) | (hl_b & ch_q);

		p_new  = op_q.rise ? n_b : p_b;
		ps_new = op_q.acc ? sp_b : ps_b;
		hs_new = op_q.acc ? sh_b : hs_b;
		if (op_q.acc) begin
			hl_new = 1'b0;
		end else if (op_q.rec) begin
			hl_new = diff_b;
		end else begin
			hl_new = hl_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			op_q    <= '0;
			brw_q   <= 1'b0;
			cp_q    <= 1'b0;
			ch_q    <= 1'b0;
			start_q <= '0;
			hlen_q  <= '0;
			psum_q  <= '0;
			hsum_q  <= '0;
		end else if (op.start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			op_q   <= op;
			brw_q  <= 1'b0;
			cp_q   <= 1'b0;
			ch_q   <= 1'b0;
		end else if (busy_q) begin
			start_q <= {p_new, start_q[TIME_WIDTH-1:1]};
			hlen_q  <= {hl_new, hlen_q[TIME_WIDTH-1:1]};
			psum_q  <= {ps_new, psum_q[TIME_WIDTH-1:1]};
			hsum_q  <= {hs_new, hsum_q[TIME_WIDTH-1:1]};
			brw_q   <= brw_d;
			cp_q    <= cp_d;
			ch_q    <= ch_d;
			cnt_q   <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.start && !busy_q) begin
			now_q <= now;
		end else if (busy_q) begin
			now_q <= {1'b0, now_q[TIME_WIDTH-1:1]};
		end
	end

	assign done       = busy_q && (cnt_q == CNT_LAST);
	assign high_sum   = hsum_q;
	assign period_sum = psum_q;

endmodule

### hdl/pdsd_div.sv
`timescale 1ns / 1ps
// radix-2 restoring divider for 100 * high sum / period sum, one quotient bit per cycle
module pdsd_div #(
	parameter int TIME_WIDTH = pdsd_pkg::TIME_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [TIME_WIDTH-1:0]           high_sum,
	input  logic [TIME_WIDTH-1:0]           period_sum,
	output logic [pdsd_pkg::RATIO_W-1:0]    ratio,
	output logic                            over,
	output logic                            done
);
	import pdsd_pkg::*;

	localparam int NW    = TIME_WIDTH + RATIO_W;
	localparam int CNT_W = $clog2(NW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

	div_state_t            state_q;
	div_state_t            state_d;
	logic [NW-1:0]         n_q;
	logic [TIME_WIDTH-1:0] r_q;
	logic [RATIO_W-1:0]    qv_q;
	logic                  over_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  ld1, ld2, step;
	logic [NW-1:0]         h_ext;
	logic [TIME_WIDTH:0]   trial;
	logic [TIME_WIDTH:0]   diff;
	logic                  ge;

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: if (start) state_d = DIV_MUL1;
			DIV_MUL1: state_d = DIV_MUL2;
			DIV_MUL2: state_d = DIV_RUN;
			DIV_RUN:  if (cnt_q == CNT_LAST) state_d = DIV_FIN;
			DIV_FIN:  state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		ld1  = 1'b0;
		ld2  = 1'b0;
		step = 1'b0;
		done = 1'b0;
		case (state_q)
			DIV_MUL1: ld1 = 1'b1;
			DIV_MUL2: ld2 = 1'b1;
			DIV_RUN:  step = 1'b1;
			DIV_FIN:  done = 1'b1;
			default:  ;
		endcase
	end

	always_comb begin
		h_ext = {{RATIO_W{1'b0}}, high_sum};
		trial = {r_q, n_q[NW-1]};
		diff  = trial - {1'b0, period_sum};
		ge    = trial >= {1'b0, period_sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ld2) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// 100 = 64 + 32 + 4, built in the load states DIV_MUL1 and DIV_MUL2
	always_ff @(posedge clk) begin
		if (ld1) begin
			n_q <= (h_ext << 6) + (h_ext << 5);
		end else if (ld2) begin
			n_q    <= n_q + (h_ext << 2);
			r_q    <= '0;
			qv_q   <= '0;
			over_q <= 1'b0;
		end else if (step) begin
			n_q    <= n_q << 1;
			r_q    <= ge ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
			qv_q   <= {qv_q[RATIO_W-2:0], ge};
			over_q <= over_q | qv_q[RATIO_W-1];
		end
	end

	assign ratio = qv_q;
	assign over  = over_q;

endmodule

### hdl/pwm_duty_speed_detector.sv
`timescale 1ns / 1ps
// top level of the pwm duty cycle speed detector
//
// input words arrive on s_tvalid/s_tready; s_tuser selects a pin sample (0) or a
// window end (1), s_tdata carries the pin level and the microsecond timestamp.
// a sample with no level change is taken while idle and gives nothing.
// a level change runs through the bit-serial edge unit, during which s_tready stays
// low. a window end gives one result word on m_tvalid/m_tready: speed 0..12,
// changed and stopped flags. with a period seen the bit-serial divider runs
// TIME_WIDTH + 7 steps after its load states DIV_MUL1 and DIV_MUL2; in either
// case the result word is registered in ST_EMIT once the output register is free.
// results sit in an output register; a stalled receiver holds it, and the block
// finishes at most one more window before it waits for that register to drain.
// reset: level low, stopped set, speed 0, sums cleared, output empty.
module pwm_duty_speed_detector #(
	parameter int TIME_WIDTH = pdsd_pkg::TIME_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pdsd_pkg::S_TDATA_W-1:0]   s_tdata,  // level, time_us, zero pad
	input  logic                             s_tuser,  // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pdsd_pkg::M_TDATA_W-1:0]   m_tdata   // speed, changed, stopped, zero pad
);
	import pdsd_pkg::*;

	state_t                state_q;
	state_t                state_d;

	logic                  prev_level_q;
	logic                  stopped_q;
	logic                  start_valid_q;
	logic                  high_valid_q;
	logic                  period_seen_q;
	logic [SPEED_W-1:0]    speed_q;
	logic                  win_level_q;
	logic                  win_seen_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	logic                  cmd;
	logic                  lvl;
	logic [TIME_IN_W-1:0]  time_us;
	logic [TIME_WIDTH-1:0] now;
	logic                  accept;
	logic                  is_edge;
	logic                  is_window;
	logic                  hv_eff;
	logic                  sv_eff;
	logic                  out_free;
	logic                  emit;
	logic                  div_start;
	edge_op_t              op;

	logic [TIME_WIDTH-1:0] high_sum;
	logic [TIME_WIDTH-1:0] period_sum;
	logic                  edge_done;
	logic [RATIO_W-1:0]    ratio;
	logic                  over;
	logic                  div_done;
	logic [SPEED_W-1:0]    next_speed;

	assign cmd     = s_tuser;
	assign lvl     = s_tdata[0];
	assign time_us = s_tdata[TIME_IN_W:1];

	generate
		if (TIME_WIDTH <= TIME_IN_W) begin : g_now_cut
			assign now = time_us[TIME_WIDTH-1:0];
		end else begin : g_now_ext
			assign now = {{(TIME_WIDTH - TIME_IN_W){1'b0}}, time_us};
		end
	endgenerate

	assign accept    = s_tvalid && s_tready;
	assign is_edge   = (cmd == CMD_SAMPLE) && (lvl != prev_level_q);
	assign is_window = (cmd == CMD_WINDOW);
	assign hv_eff    = high_valid_q & ~stopped_q;
	assign sv_eff    = start_valid_q & ~stopped_q;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_edge) begin
					state_d = ST_EDGE;
				end else if (accept && is_window) begin
					state_d = period_seen_q ? ST_DIV : ST_EMIT;
				end
			end
			ST_EDGE: if (edge_done) state_d = ST_IDLE;
			ST_DIV:  if (div_done) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		emit      = (state_q == ST_EMIT) && out_free;
		div_start = accept && is_window && period_seen_q;
		op.start  = accept && is_edge;
		op.clr    = stopped_q;
		op.rise   = lvl;
		op.acc    = lvl & hv_eff;
		op.rec    = ~lvl & sv_eff;
	end

	always_comb begin
		if (win_seen_q) begin
			next_speed = speed_of_ratio(ratio, over);
		end else begin
			next_speed = win_level_q ? SPEED_MAX : SPEED_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_level_q  <= 1'b0;
			stopped_q     <= 1'b1;
			start_valid_q <= 1'b0;
			high_valid_q  <= 1'b0;
			period_seen_q <= 1'b0;
			speed_q       <= SPEED_OFF;
			win_level_q   <= 1'b0;
			win_seen_q    <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept && is_edge) begin
				prev_level_q  <= lvl;
				stopped_q     <= 1'b0;
				start_valid_q <= lvl | sv_eff;
				high_valid_q  <= ~lvl & (sv_eff | hv_eff);
				if (lvl && hv_eff) begin
					period_seen_q <= 1'b1;
				end
			end
			if (accept && is_window) begin
				period_seen_q <= 1'b0;
				win_level_q   <= lvl;
				win_seen_q    <= period_seen_q;
				if (!period_seen_q) begin
					stopped_q <= 1'b1;
				end
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {2'b00, ~win_seen_q, next_speed != speed_q, next_speed};
				speed_q    <= next_speed;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	pdsd_edge_acc #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_edge (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.now        (now),
		.high_sum   (high_sum),
		.period_sum (period_sum),
		.done       (edge_done)
	);

	pdsd_div #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.high_sum   (high_sum),
		.period_sum (period_sum),
		.ratio      (ratio),
		.over       (over),
		.done       (div_done)
	);

endmodule

### hdl/pdsd_checker.sv
`timescale 1ns / 1ps
// port-level checks of the pwm speed detector and their binding
module pdsd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [pdsd_pkg::M_TDATA_W-1:0]   m_tdata
);
	import pdsd_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[3:0] <= SPEED_MAX && m_tdata[7:6] == 2'b00)
		else $error("speed out of range or pad bits set");

	// stopped result comes from the pin level only
	a_stopped_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> m_tdata[3:0] == SPEED_OFF || m_tdata[3:0] == SPEED_MAX)
		else $error("stopped result with intermediate speed");

	// a taken window word moves the block out of idle, so the input is not ready while it is handled
	a_window_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_WINDOW |=> !s_tready)
		else $error("input ready right after a window word");

endmodule

bind pwm_duty_speed_detector pdsd_checker u_pdsd_checker (.*);

### verif/pwm_duty_speed_detector_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the pwm duty cycle speed detector
module pwm_duty_speed_detector_test;
	import pdsd_pkg::*;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               changed;
		logic               stopped;
	} speed_word_t;

	class speed_scoreboard;
		logic               prev_pin;
		logic               is_stopped;
		logic [31:0]        rise_time;
		logic [31:0]        high_time;
		logic [31:0]        period_total;
		logic [31:0]        high_total;
		logic               got_period;
		logic [SPEED_W-1:0] last_speed;
		logic               rise_known;
		logic               high_known;
		speed_word_t        speed_q[$];
		int                 errors;

		function new();
			prev_pin     = 1'b0;
			is_stopped   = 1'b1;
			rise_time    = '0;
			high_time    = '0;
			period_total = '0;
			high_total   = '0;
			got_period   = 1'b0;
			last_speed   = SPEED_OFF;
			rise_known   = 1'b0;
			high_known   = 1'b0;
			errors       = 0;
		endfunction

		// returns 1 when the word does something, 0 when the block ignores it
		function bit note_input(logic cmd, logic lvl, logic [31:0] t);
			logic [63:0]        scaled_high;
			logic [SPEED_W-1:0] s;
			speed_word_t        w;
			if (cmd == CMD_SAMPLE) begin
				if (lvl == prev_pin) begin
					return 1'b0;
				end
				prev_pin = lvl;
				if (is_stopped) begin
					rise_time    = '0;
					high_time    = '0;
					period_total = '0;
					high_total   = '0;
					rise_known   = 1'b0;
					high_known   = 1'b0;
					is_stopped   = 1'b0;
				end
				if (lvl) begin
					if (high_known) begin
						high_total   = high_total + high_time;
						high_time    = '0;
						high_known   = 1'b0;
						period_total = period_total + (t - rise_time);
						got_period   = 1'b1;
					end
					rise_time  = t;
					rise_known = 1'b1;
				end else if (rise_known) begin
					high_time  = t - rise_time;
					high_known = 1'b1;
				end
				return 1'b1;
			end
			if (!got_period) begin
				is_stopped = 1'b1;
				s = lvl ? SPEED_MAX : SPEED_OFF;
			end else if (period_total == 0) begin
				s = SPEED_MAX;
			end else begin
				// full width: ratio above table entry k means 100*high >= (DUTY_TABLE[k] + 1)*period
				scaled_high = 64'(high_total) * 64'd100;
				s = SPEED_OFF;
				while (s < SPEED_MAX &&
					scaled_high >= 64'(period_total) * (64'(DUTY_TABLE[s]) + 64'd1)) begin
					s = s + 1'b1;
				end
			end
			w.speed   = s;
			w.changed = (s != last_speed);
			w.stopped = !got_period;
			got_period = 1'b0;
			last_speed = s;
			speed_q.insert(speed_q.size(), w);
			return 1'b1;
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] word);
			speed_word_t exp_w;
			if (speed_q.size() == 0) begin
				$error("speed word with none pending: %h", word);
				errors++;
				return;
			end
			exp_w = speed_q[0];
			speed_q.delete(0);
			if (word[3:0] !== exp_w.speed) begin
				$error("speed: expected %0d, actual %0d", exp_w.speed, word[3:0]);
				errors++;
			end
			if (word[4] !== exp_w.changed) begin
				$error("changed: expected %0d, actual %0d", exp_w.changed, word[4]);
				errors++;
			end
			if (word[5] !== exp_w.stopped) begin
				$error("stopped: expected %0d, actual %0d", exp_w.stopped, word[5]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;

	speed_scoreboard sb = new();
	int              src_idle;
	int              dst_idle;
	int              words_taken;
	logic            pin;
	logic [31:0]     now_us;

	pwm_duty_speed_detector i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= dst_idle);
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
		end
	end

	task automatic put_word(input logic cmd, input logic lvl, input logic [31:0] t);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, t, lvl};
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (sb.note_input(cmd, lvl, t)) begin
			words_taken++;
		end
		if (cmd == CMD_SAMPLE) begin
			pin = lvl;
		end
	endtask

	// a run of pwm periods with random period and duty, closed by a window word
	task automatic pwm_burst();
		int          n;
		logic [31:0] period;
		logic [31:0] high;
		n = $urandom_range(1, 6);
		if ($urandom_range(3) == 0) begin
			period = $urandom;
		end else begin
			period = $urandom_range(1, 20000);
		end
		if (pin) begin
			put_word(CMD_SAMPLE, 1'b0, now_us);
			now_us += $urandom_range(1, 500);
		end
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(7))
				0: high = 0;
				1: high = period;
				default: high = $urandom_range(0, period);
			endcase
			put_word(CMD_SAMPLE, 1'b1, now_us);
			if ($urandom_range(7) == 0) begin
				put_word(CMD_SAMPLE, 1'b1, $urandom);
			end
			put_word(CMD_SAMPLE, 1'b0, now_us + high);
			now_us += period;
			if ($urandom_range(9) == 0) begin
				period = $urandom_range(1, 20000);
			end
		end
		if ($urandom_range(5) != 0) begin
			put_word(CMD_SAMPLE, 1'b1, now_us);
		end
		put_word(CMD_WINDOW, ($urandom_range(4) == 0) ? 1'($urandom) : pin, $urandom);
	endtask

	task automatic random_phase(input int target);
		int r;
		while (words_taken < target) begin
			r = $urandom_range(99);
			if (r < 75) begin
				pwm_burst();
			end else if (r < 85) begin
				put_word(CMD_WINDOW, 1'($urandom), $urandom);
			end else begin
				repeat ($urandom_range(1, 5)) begin
					put_word(($urandom_range(5) == 0) ? CMD_WINDOW : CMD_SAMPLE,
						1'($urandom), $urandom);
				end
			end
			if ($urandom_range(9) == 0) begin
				now_us = $urandom;
			end
		end
	endtask

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = CMD_SAMPLE;
		m_tready    = 1'b0;
		src_idle    = 10;
		dst_idle    = 57;
		words_taken = 0;
		pin         = 1'b0;
		now_us      = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window right after reset, ignored sample, window with pin high
		put_word(CMD_WINDOW, 1'b0, 32'h0000_0000);
		put_word(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF);
		put_word(CMD_WINDOW, 1'b1, 32'hFFFF_FFFF);
		// one clean half duty period
		put_word(CMD_SAMPLE, 1'b1, 32'd100);
		put_word(CMD_SAMPLE, 1'b0, 32'd150);
		put_word(CMD_SAMPLE, 1'b1, 32'd200);
		put_word(CMD_WINDOW, 1'b1, 32'd300);
		put_word(CMD_WINDOW, 1'b1, 32'd400);
		// fall with no rise, rise with no high time, then a zero length period
		put_word(CMD_SAMPLE, 1'b0, 32'd10);
		put_word(CMD_SAMPLE, 1'b1, 32'd20);
		put_word(CMD_SAMPLE, 1'b0, 32'd20);
		put_word(CMD_SAMPLE, 1'b1, 32'd20);
		put_word(CMD_WINDOW, 1'b1, 32'd30);
		// long period, product beyond 32 bits
		put_word(CMD_SAMPLE, 1'b0, 32'h8000_0000);
		put_word(CMD_SAMPLE, 1'b1, 32'hF000_0000);
		put_word(CMD_WINDOW, 1'b0, 32'hF000_0001);
		// wrapped high time bigger than the period
		put_word(CMD_SAMPLE, 1'b0, 32'h7FFF_FFFF);
		put_word(CMD_SAMPLE, 1'b1, 32'hF000_0010);
		put_word(CMD_WINDOW, 1'b0, 32'hF000_0020);
		// tiny duty
		put_word(CMD_SAMPLE, 1'b0, 32'hF000_0011);
		put_word(CMD_SAMPLE, 1'b1, 32'hF000_03F8);
		put_word(CMD_WINDOW, 1'b1, 32'hF000_0400);

		random_phase(words_taken + 630);
		src_idle = 57;
		dst_idle = 10;
		random_phase(words_taken + 630);
		src_idle = 0;
		dst_idle = 0;
		random_phase(words_taken + 630);
		s_tvalid <= 1'b0;

		while (sb.speed_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### files.f
hdl/pdsd_pkg.sv
hdl/pdsd_edge_acc.sv
hdl/pdsd_div.sv
hdl/pwm_duty_speed_detector.sv
hdl/pdsd_checker.sv
verif/pwm_duty_speed_detector_test.sv
